// File: hdl/clns_pkg.sv
// Shared types, constants and the power-up step table of the LCD nibble sequencer.
`timescale 1ns / 1ps
`default_nettype none

package clns_pkg;

  // Field widths.
  localparam int unsigned FuncW  = 3;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned NibW   = 4;
  localparam int unsigned WaitW  = 16;
  localparam int unsigned CharsW = 6;
  localparam int unsigned AddrW  = 7;
  localparam int unsigned StepW  = 4;

  // Number of bus steps in the power-up sequence.
  localparam int unsigned InitSteps = 11;

  // Reset value of the characters-per-row register.
  localparam logic [CharsW-1:0] CharsReset = 6'd16;

  // Controller command bits.
  localparam logic [ByteW-1:0] CmdSetDdram   = 8'h80;
  localparam logic [ByteW-1:0] CmdSetCgram   = 8'h40;
  localparam logic [ByteW-1:0] CmdFuncSet    = 8'h20;
  localparam logic [ByteW-1:0] CmdDispCtrl   = 8'h08;
  localparam logic [ByteW-1:0] CmdClear      = 8'h01;
  localparam logic [ByteW-1:0] CmdHome       = 8'h02;
  localparam logic [AddrW-1:0] RowTwoOffset  = 7'h40;

  // Wait times in microseconds.
  localparam logic [WaitW-1:0] WaitPowerUp = 16'd50000;
  localparam logic [WaitW-1:0] WaitInitA   = 16'd4500;
  localparam logic [WaitW-1:0] WaitInitB   = 16'd150;
  localparam logic [WaitW-1:0] WaitLong    = 16'd2000;
  localparam logic [WaitW-1:0] WaitNone    = 16'd0;

  // Operation codes of the input item.
  typedef enum logic [FuncW-1:0] {
    FuncInit    = 3'd0,
    FuncCommand = 3'd1,
    FuncData    = 3'd2,
    FuncCursor  = 3'd3,
    FuncClear   = 3'd4,
    FuncHome    = 3'd5,
    FuncDisplay = 3'd6,
    FuncGlyph   = 3'd7
  } func_e;

  // One classified operation, as held in the queue.
  typedef struct packed {
    logic             is_init;
    logic             rs;
    logic [ByteW-1:0] data;
    logic             long_wait;
  } op_t;

  // One bus step.
  typedef struct packed {
    logic             rs;
    logic [NibW-1:0]  nibble;
    logic             strobe;
    logic [WaitW-1:0] wait_us;
    logic             last;
  } step_t;

  // Power-up sequence: a wait, the 8-bit wake-up nibbles, the switch to
  // 4-bit mode, then function set, display on and clear.
  function automatic step_t init_step(input logic [StepW-1:0] idx);
    step_t s;
    s = '{rs: 1'b0, nibble: 4'h0, strobe: 1'b1, wait_us: WaitNone, last: 1'b0};
    case (idx)
      4'd0: begin
        s.strobe  = 1'b0;
        s.wait_us = WaitPowerUp;
      end
      4'd1: begin
        s.nibble  = 4'h3;
        s.wait_us = WaitInitA;
      end
      4'd2: begin
        s.nibble  = 4'h3;
        s.wait_us = WaitInitA;
      end
      4'd3: begin
        s.nibble  = 4'h3;
        s.wait_us = WaitInitB;
      end
      4'd4: s.nibble = 4'h2;
      4'd5: s.nibble = 4'h2;
      4'd6: s.nibble = 4'h8;
      4'd7: s.nibble = 4'h0;
      4'd8: s.nibble = 4'hC;
      4'd9: s.nibble = 4'h0;
      4'd10: begin
        s.nibble  = 4'h1;
        s.wait_us = WaitLong;
        s.last    = 1'b1;
      end
      default: s = '0;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

// File: hdl/char_lcd_nibble_sequencer.sv
// Top level of the character-LCD 4-bit bus nibble sequencer.
// Usage:
//   Input channel (in_valid_i / in_ready_o) takes one display operation per
//   item: power-up init, raw command, data byte, cursor placement, clear,
//   home, display control or glyph slot select.
//   Output channel (out_valid_o / out_ready_i) gives one bus step per item:
//   register select, nibble, enable pulse flag, extra wait and a last flag
//   on the final step of each operation. Real timing is done downstream.
//   cfg_we_i writes the characters-per-row register; write it while idle.
// Path: an accepted operation is written into the queue, and its first step
//   is then loaded into the output register.
// Throughput: the back-end sequencer emits one step per cycle while out_ready_i
//   is not held low; byte operations go out as a high and a low nibble step.
// A two-entry queue between the classifier and the sequencer keeps input
//   acceptance going while steps are stalled; when the receiver holds
//   out_ready_i low, the output holds and in_ready_o drops once the queue
//   is full.
// Reset empties the queue and output, and sets 16 characters per row.
`timescale 1ns / 1ps
`default_nettype none

module char_lcd_nibble_sequencer
  import clns_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [CharsW-1:0] cfg_wdata_i,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic [FuncW-1:0]  func_i,
  input  wire logic [ByteW-1:0]  value_i,
  input  wire logic [1:0]        row_i,
  input  wire logic [5:0]        col_i,
  input  wire logic              display_on_i,
  input  wire logic              cursor_on_i,
  input  wire logic              blink_on_i,
  input  wire logic [2:0]        glyph_slot_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic                   reg_select_o,
  output logic [NibW-1:0]        nibble_o,
  output logic                   strobe_res_o,
  output logic [WaitW-1:0]       wait_us_o,
  output logic                   last_o
);

  op_t   new_op;
  op_t   head_op;
  logic  q_full;
  logic  q_valid;
  logic  q_pop;
  logic  push;
  step_t step;

  assign in_ready_o = !q_full;
  assign push       = in_valid_i && in_ready_o;

  // Classification of incoming items.
  clns_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .func_i       (func_i),
    .value_i      (value_i),
    .row_i        (row_i),
    .col_i        (col_i),
    .display_on_i (display_on_i),
    .cursor_on_i  (cursor_on_i),
    .blink_on_i   (blink_on_i),
    .glyph_slot_i (glyph_slot_i),
    .op_o         (new_op)
  );

  // Decoupling queue.
  clns_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .push_op_i (new_op),
    .full_o    (q_full),
    .pop_i     (q_pop),
    .valid_o   (q_valid),
    .head_o    (head_op)
  );

  // Step sequencer and output register.
  clns_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .op_valid_i  (q_valid),
    .op_i        (head_op),
    .pop_o       (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .step_o      (step)
  );

  assign reg_select_o = step.rs;
  assign nibble_o     = step.nibble;
  assign strobe_res_o = step.strobe;
  assign wait_us_o    = step.wait_us;
  assign last_o       = step.last;

endmodule

`default_nettype wire

// File: hdl/clns_front.sv
// Front end: holds the row-width register and turns each input item into a queued operation.
`timescale 1ns / 1ps
`default_nettype none

module clns_front
  import clns_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [CharsW-1:0] cfg_wdata_i,
  input  wire logic [FuncW-1:0]  func_i,
  input  wire logic [ByteW-1:0]  value_i,
  input  wire logic [1:0]        row_i,
  input  wire logic [5:0]        col_i,
  input  wire logic              display_on_i,
  input  wire logic              cursor_on_i,
  input  wire logic              blink_on_i,
  input  wire logic [2:0]        glyph_slot_i,
  output op_t                    op_o
);

  logic [CharsW-1:0] chars_q, chars_d;
  logic [AddrW-1:0]  offset;
  logic [AddrW-1:0]  addr;
  func_e             func;

  // Characters-per-row register.
  always_comb begin
    chars_d = cfg_we_i ? cfg_wdata_i : chars_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chars_q <= CharsReset;
    end else begin
      chars_q <= chars_d;
    end
  end

  // Display address for cursor placement, wrapped to seven bits.
  always_comb begin
    case (row_i)
      2'd0:    offset = '0;
      2'd1:    offset = RowTwoOffset;
      2'd2:    offset = {1'b0, chars_q};
      default: offset = RowTwoOffset + {1'b0, chars_q};
    endcase
    addr = AddrW'({1'b0, col_i} + offset);
  end

  // Classify the operation into a byte and its trailing wait.
  always_comb begin
    func = func_e'(func_i);
    op_o = '{is_init: 1'b0, rs: 1'b0, data: '0, long_wait: 1'b0};
    case (func)
      FuncInit:    op_o.is_init = 1'b1;
      FuncCommand: op_o.data = value_i;
      FuncData: begin
        op_o.rs   = 1'b1;
        op_o.data = value_i;
      end
      FuncCursor:  op_o.data = CmdSetDdram | {1'b0, addr};
      FuncClear: begin
        op_o.data      = CmdClear;
        op_o.long_wait = 1'b1;
      end
      FuncHome: begin
        op_o.data      = CmdHome;
        op_o.long_wait = 1'b1;
      end
      FuncDisplay: op_o.data = CmdDispCtrl | {5'd0, display_on_i, cursor_on_i, blink_on_i};
      FuncGlyph:   op_o.data = CmdSetCgram | {2'd0, glyph_slot_i, 3'd0};
      default:     op_o.data = value_i;
    endcase
  end

endmodule

`default_nettype wire

// File: hdl/clns_queue.sv
// Two-entry queue of classified operations between the front and back ends.
`timescale 1ns / 1ps
`default_nettype none

module clns_queue
  import clns_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire op_t  push_op_i,
  output logic      full_o,
  input  wire logic pop_i,
  output logic      valid_o,
  output op_t       head_o
);

  op_t        mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       do_pop;

  assign full_o  = (count_q == 2'd2);
  assign valid_o = (count_q != 2'd0);
  assign head_o  = mem_q[rd_ptr_q];
  assign do_pop  = pop_i && valid_o;

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = push_i ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !do_pop) begin
      count_d = count_q + 2'd1;
    end else if (!push_i && do_pop) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_op_i;
    end
  end

  // The fill count never goes beyond two entries.
  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q != 2'd3)
    else $error("queue count out of range");

  // Pointers differ exactly when the queue holds one entry.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_ptr_q != rd_ptr_q) == (count_q == 2'd1))
    else $error("queue pointers disagree with count");

endmodule

`default_nettype wire

// File: hdl/clns_back.sv
// Back end: walks each queued operation through its bus steps into the output register.
`timescale 1ns / 1ps
`default_nettype none

module clns_back
  import clns_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              op_valid_i,
  input  wire op_t               op_i,
  output logic                   pop_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output step_t                  step_o
);

  logic [StepW-1:0] idx_q, idx_d;
  logic             out_valid_q, out_valid_d;
  step_t            step_q, step_d;
  step_t            cur;
  logic             load;

  // Step for the current position in the head operation.
  always_comb begin
    if (op_i.is_init) begin
      cur = init_step(idx_q);
    end else if (idx_q == '0) begin
      cur = '{rs: op_i.rs, nibble: op_i.data[7:4], strobe: 1'b1,
              wait_us: WaitNone, last: 1'b0};
    end else begin
      cur = '{rs: op_i.rs, nibble: op_i.data[3:0], strobe: 1'b1,
              wait_us: (op_i.long_wait ? WaitLong : WaitNone), last: 1'b1};
    end
  end

  // A step moves into the output register whenever it is empty or being taken.
  assign load  = op_valid_i && (!out_valid_q || out_ready_i);
  assign pop_o = load && cur.last;

  always_comb begin
    idx_d       = idx_q;
    out_valid_d = out_valid_q;
    step_d      = step_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (load) begin
      out_valid_d = 1'b1;
      step_d      = cur;
      idx_d       = cur.last ? '0 : idx_q + StepW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    step_q <= step_d;
  end

  assign out_valid_o = out_valid_q;
  assign step_o      = step_q;

  // A sequence in progress always has its operation at the queue head.
  assert property (@(posedge clk_i) disable iff (!rst_ni) (idx_q != '0) |-> op_valid_i)
    else $error("step index advanced with an empty queue");

  // Byte operations never go past their second step.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (op_valid_i && !op_i.is_init) |-> (idx_q <= StepW'(1)))
    else $error("byte operation step index out of range");

  // The step index stays within the power-up sequence.
  assert property (@(posedge clk_i) disable iff (!rst_ni) idx_q < StepW'(InitSteps))
    else $error("step index beyond power-up sequence");

  // Popping the queue happens only together with loading a final step.
  assert property (@(posedge clk_i) disable iff (!rst_ni) pop_o |=> (out_valid_q && step_q.last))
    else $error("queue popped without a final step");

endmodule

`default_nettype wire
